// ----- rtl/lcsm_pkg.sv -----
// Shared types and constants for the LCD controller serial master.
// Used by the front end, the job queue, the slot sequencer and the checker.
`default_nettype none
package lcsm_pkg;

  localparam int BITS_W     = 17;
  localparam int NB_W       = 5;
  localparam int RD_W       = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [RD_W-1:0] RD_CNT   = 3'd4;
  localparam logic [2:0]      ID_CMD   = 3'b100;
  localparam logic [2:0]      ID_WRITE = 3'b101;

  typedef enum logic [1:0] {
    SLOT_ASSERT  = 2'd0,
    SLOT_WRITE   = 2'd1,
    SLOT_READ    = 2'd2,
    SLOT_RELEASE = 2'd3
  } slot_t;

  typedef enum logic [2:0] {
    ACT_CMD     = 3'd0,
    ACT_NIBBLE  = 3'd1,
    ACT_BURST   = 3'd2,
    ACT_RMW_GO  = 3'd3,
    ACT_RMW_FIN = 3'd4
  } act_t;

  // One queued job: optional select assert, a run of write bits (bit 0 goes
  // out first), a number of read strobes and an optional select release.
  typedef struct packed {
    logic              asrt;
    logic [BITS_W-1:0] bits;
    logic [NB_W-1:0]   nbits;
    logic [RD_W-1:0]   nrd;
    logic              rel;
  } job_t;

endpackage
`default_nettype wire

// ----- rtl/lcsm_front.sv -----
// Front end: accepts requests, tracks frame and RMW state and turns each
// request but a stray RMW finish or bad action into a job. Uses lcsm_pkg.
`default_nettype none
module lcsm_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc,
  input  wire logic [2:0]    action,
  input  wire logic [5:0]    address,
  input  wire logic [7:0]    data,
  input  wire logic [3:0]    mask,
  input  wire logic          set_bits,
  input  wire logic          first,
  input  wire logic          last,
  output lcsm_pkg::job_t     job,
  output logic               push
);
  import lcsm_pkg::*;

  logic       rmw_wait_r, rmw_wait_nxt;
  logic [3:0] mask_r, mask_nxt;
  logic       set_r, set_nxt;
  logic       frame_r, frame_nxt;
  logic [8:0] hdr;
  logic [11:0] cmd;
  logic [3:0] rmw_val;
  logic       emit;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hdr[i] = ID_WRITE[2-i];
      cmd[i] = ID_CMD[2-i];
    end
    for (int i = 0; i < 6; i++) begin
      hdr[3+i] = address[5-i];
    end
    for (int i = 0; i < 8; i++) begin
      cmd[3+i] = data[7-i];
    end
    cmd[11] = 1'b0;
  end

  assign rmw_val = set_r ? (data[3:0] | mask_r) : (data[3:0] & ~mask_r);

  always_comb begin
    rmw_wait_nxt = rmw_wait_r;
    mask_nxt     = mask_r;
    set_nxt      = set_r;
    frame_nxt    = frame_r;
    emit         = 1'b1;
    job          = '0;
    unique case (action)
      ACT_CMD: begin
        rmw_wait_nxt = 1'b0;
        frame_nxt    = 1'b0;
        job.asrt     = 1'b1;
        job.bits     = {5'b0, cmd};
        job.nbits    = 5'd12;
        job.rel      = 1'b1;
      end
      ACT_NIBBLE: begin
        rmw_wait_nxt = 1'b0;
        frame_nxt    = 1'b0;
        job.asrt     = 1'b1;
        job.bits     = {4'b0, data[3:0], hdr};
        job.nbits    = 5'd13;
        job.rel      = 1'b1;
      end
      ACT_BURST: begin
        rmw_wait_nxt = 1'b0;
        frame_nxt    = ~last;
        job.rel      = last;
        if (first || !frame_r) begin
          job.asrt  = 1'b1;
          job.bits  = {data, hdr};
          job.nbits = 5'd17;
        end else begin
          job.bits  = {9'b0, data};
          job.nbits = 5'd8;
        end
      end
      ACT_RMW_GO: begin
        frame_nxt    = 1'b0;
        rmw_wait_nxt = 1'b1;
        mask_nxt     = mask;
        set_nxt      = set_bits;
        job.asrt     = 1'b1;
        job.bits     = {8'b0, hdr};
        job.nbits    = 5'd9;
        job.nrd      = RD_CNT;
      end
      ACT_RMW_FIN: begin
        emit         = rmw_wait_r;
        rmw_wait_nxt = 1'b0;
        job.bits     = {13'b0, rmw_val};
        job.nbits    = 5'd4;
        job.rel      = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign push = acc && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmw_wait_r <= 1'b0;
      mask_r     <= '0;
      set_r      <= 1'b0;
      frame_r    <= 1'b0;
    end else if (acc) begin
      rmw_wait_r <= rmw_wait_nxt;
      mask_r     <= mask_nxt;
      set_r      <= set_nxt;
      frame_r    <= frame_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lcsm_fifo.sv -----
// Short job queue between the front end and the slot sequencer.
// Depends on lcsm_pkg for the job type and depth.
`default_nettype none
module lcsm_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  lcsm_pkg::job_t      wr_data,
  output logic                full,
  input  wire logic           rd_en,
  output lcsm_pkg::job_t      rd_data,
  output logic                empty
);
  import lcsm_pkg::*;

  job_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;

  assign full    = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= rp_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lcsm_back.sv -----
// Slot sequencer: plays queued jobs out as one pin slot per cycle, unless
// the output stalls, into an output register. Depends on lcsm_pkg.
`default_nettype none
module lcsm_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  lcsm_pkg::job_t      head,
  input  wire logic           empty,
  output logic                pop,
  output logic                out_vld,
  input  wire logic           out_rdy,
  output logic [1:0]          out_kind,
  output logic                out_bit,
  output logic                out_last
);
  import lcsm_pkg::*;

  job_t  work_r, cur, rem;
  logic  busy_r;
  logic  vld_r;
  slot_t kind_r, kind;
  logic  bit_r, sbit, last_r, done, fire;

  assign cur  = busy_r ? work_r : head;
  assign fire = (busy_r || !empty) && (!vld_r || out_rdy);
  assign pop  = fire && !busy_r;

  always_comb begin
    rem  = cur;
    sbit = 1'b0;
    if (cur.asrt) begin
      kind     = SLOT_ASSERT;
      rem.asrt = 1'b0;
    end else if (cur.nbits != '0) begin
      kind      = SLOT_WRITE;
      sbit      = cur.bits[0];
      rem.bits  = cur.bits >> 1;
      rem.nbits = cur.nbits - 1'b1;
    end else if (cur.nrd != '0) begin
      kind    = SLOT_READ;
      rem.nrd = cur.nrd - 1'b1;
    end else begin
      kind    = SLOT_RELEASE;
      rem.rel = 1'b0;
    end
    done = !rem.asrt && (rem.nbits == '0) && (rem.nrd == '0) && !rem.rel;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      work_r <= rem;
      kind_r <= kind;
      bit_r  <= sbit;
      last_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      if (fire) begin
        busy_r <= !done;
        vld_r  <= 1'b1;
      end else if (out_rdy) begin
        vld_r  <= 1'b0;
      end
    end
  end

  assign out_vld  = vld_r;
  assign out_kind = kind_r;
  assign out_bit  = bit_r;
  assign out_last = last_r;

endmodule
`default_nettype wire

// ----- rtl/lcd_controller_serial_master_core.sv -----
// Top level of the LCD controller serial master: front end, job queue and
// slot sequencer. Depends on lcsm_pkg, lcsm_front, lcsm_fifo and lcsm_back.
//
//   Channel | Direction | Carries
//   in_*    | slave     | one request per transaction
//   out_*   | master    | one pin slot per transaction
//
// The sequencer issues one slot per cycle while the output is not stalled,
// and a request has 5 to 19 slots. The sequencer turns from one job to the next
// without a gap. A four-entry job queue lets requests be accepted while the
// sequencer and a stalled output are busy. Reset empties the queue and clears
// the frame and read-modify-write state. Output stalls hold the slot register.
`default_nettype none
module lcd_controller_serial_master_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // address[5:0], data[13:6], mask[17:14], set_bits[18]
  input  wire logic [3:0]  in_tuser,  // action[2:0], first[3]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata, // data_bit[0]
  output logic [1:0]       out_tuser, // slot_kind[1:0]
  output logic             out_tlast
);
  import lcsm_pkg::*;

  job_t job, head;
  logic push, full, empty, pop, acc, dbit;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  lcsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .action   (in_tuser[2:0]),
    .address  (in_tdata[5:0]),
    .data     (in_tdata[13:6]),
    .mask     (in_tdata[17:14]),
    .set_bits (in_tdata[18]),
    .first    (in_tuser[3]),
    .last     (in_tlast),
    .job      (job),
    .push     (push)
  );

  lcsm_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (job),
    .full    (full),
    .rd_en   (pop),
    .rd_data (head),
    .empty   (empty)
  );

  lcsm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_kind (out_tuser),
    .out_bit  (dbit),
    .out_last (out_tlast)
  );

  assign out_tdata = {7'b0, dbit};

endmodule
`default_nettype wire

// ----- rtl/lcsm_checker.sv -----
// Port-level checks for the LCD controller serial master, bound to the top
// level. Depends on lcsm_pkg and lcd_controller_serial_master_core.
`default_nettype none
module lcsm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [1:0] out_tuser,
  input wire logic       out_tlast
);
  import lcsm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("Stalled output transaction changed.");

  a_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != SLOT_WRITE |-> out_tdata == 8'd0)
    else $error("Data bit set outside a write slot.");

  a_release_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == SLOT_RELEASE |-> out_tlast)
    else $error("Select release is not the final slot.");

  a_assert_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == SLOT_ASSERT |-> !out_tlast)
    else $error("Select assert marked as final slot.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Output valid right after reset.");

endmodule

bind lcd_controller_serial_master_core lcsm_checker u_lcsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
